### rtl/hnfp_pkg.sv
package hnfp_pkg;

    // default width of the unit length field
    localparam int NAL_LENGTH_BITS_DEF = 16;

    // configuration register map
    localparam int          PADDR_BITS       = 3;
    localparam logic [2:0]  ADDR_MAX_PACKET  = 3'd0;
    localparam logic [11:0] MAX_PACKET_RESET = 12'd1024;
    localparam logic [11:0] MAX_PACKET_LO    = 12'd4;
    localparam logic [11:0] MAX_PACKET_HI    = 12'd2048;

    // fu-a framing
    localparam logic [11:0] FU_BYTES     = 12'd2;
    localparam logic [7:0]  NRI_MASK     = 8'hE0;
    localparam logic [7:0]  FU_A_TYPE    = 8'd28;
    localparam logic [7:0]  TYPE_MASK    = 8'h1F;
    localparam logic [7:0]  FU_START_BIT = 8'h80;
    localparam logic [7:0]  FU_END_BIT   = 8'h40;

    // one result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_first;
        logic       packet_last;
        logic       run_last;
    } beat_t;

    // results of one input byte, beat 0 goes out first
    typedef struct packed {
        logic [1:0]      count;
        beat_t [2:0]     beats;
    } load_t;

endpackage

### rtl/hnfp_nal_if.sv
interface hnfp_nal_if #(
    parameter int NAL_LENGTH_BITS = hnfp_pkg::NAL_LENGTH_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic [7:0]                 nal_byte;
    logic [NAL_LENGTH_BITS-1:0] nal_length;

    modport source (output valid, output nal_byte, output nal_length, input ready);
    modport sink   (input valid, input nal_byte, input nal_length, output ready);
endinterface

### rtl/hnfp_rtp_if.sv
interface hnfp_rtp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_first;
    logic       packet_last;
    logic       run_last;

    modport source (output valid, output out_byte, output packet_first,
                    output packet_last, output run_last, input ready);
    modport sink   (input valid, input out_byte, input packet_first,
                    input packet_last, input run_last, output ready);
endinterface

### rtl/hnfp_packer.sv
module hnfp_packer #(
    parameter int NAL_LENGTH_BITS = hnfp_pkg::NAL_LENGTH_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [7:0]                 nal_byte,
    input  logic [NAL_LENGTH_BITS-1:0] nal_length,
    input  logic [11:0]                max_packet_bytes,
    output hnfp_pkg::load_t            load
);

    localparam int CW = ((NAL_LENGTH_BITS > 12) ? NAL_LENGTH_BITS : 12) + 2;

    logic [NAL_LENGTH_BITS-1:0] byte_position_reg, byte_position_next;
    logic [7:0]                 saved_nal_header_reg, saved_nal_header_next;
    logic [10:0]                packet_fill_reg, packet_fill_next;
    logic                       fragmenting_reg, fragmenting_next;

    logic [11:0]   max_eff;
    logic [10:0]   room;
    logic [CW-1:0] pos_x, len_x, max_x, room_x;
    logic          unit_end, too_big, frag_end, frag_last;
    logic [7:0]    fu_ind, fu_hdr;

    // clamp the maximum and derive the fragment room
    always_comb
    begin
        if (max_packet_bytes < hnfp_pkg::MAX_PACKET_LO)
            max_eff = hnfp_pkg::MAX_PACKET_LO;
        else if (max_packet_bytes > hnfp_pkg::MAX_PACKET_HI)
            max_eff = hnfp_pkg::MAX_PACKET_HI;
        else
            max_eff = max_packet_bytes;
    end

    assign room   = 11'(max_eff - hnfp_pkg::FU_BYTES);
    assign pos_x  = CW'(byte_position_reg);
    assign len_x  = CW'(nal_length);
    assign max_x  = CW'(max_eff);
    assign room_x = CW'(room);

    assign unit_end  = (pos_x + CW'(1)) >= len_x;
    assign too_big   = len_x > max_x;
    assign frag_end  = (pos_x + room_x) >= len_x;
    assign frag_last = unit_end || ((12'(packet_fill_reg) + 12'd1) >= 12'(room));

    // fu indicator and fu header from the saved unit header
    always_comb
    begin
        fu_ind = (saved_nal_header_reg & hnfp_pkg::NRI_MASK) | hnfp_pkg::FU_A_TYPE;
        fu_hdr = saved_nal_header_reg & hnfp_pkg::TYPE_MASK;
        if (byte_position_reg == NAL_LENGTH_BITS'(1))
            fu_hdr = fu_hdr | hnfp_pkg::FU_START_BIT;
        if (frag_end)
            fu_hdr = fu_hdr | hnfp_pkg::FU_END_BIT;
    end

    // result beats and next state for the byte at hand
    always_comb
    begin
        load                  = '0;
        saved_nal_header_next = saved_nal_header_reg;
        packet_fill_next      = packet_fill_reg;
        fragmenting_next      = fragmenting_reg;

        if (byte_position_reg == '0)
        begin
            packet_fill_next = '0;
            if (too_big)
            begin
                // header of a fragmented unit is kept, no beat
                saved_nal_header_next = nal_byte;
                fragmenting_next      = 1'b1;
            end
            else
            begin
                fragmenting_next = 1'b0;
                load.count       = 2'd1;
                load.beats[0]    = '{out_byte: nal_byte, packet_first: 1'b1,
                                     packet_last: unit_end, run_last: 1'b1};
            end
        end
        else if (!fragmenting_reg)
        begin
            load.count    = 2'd1;
            load.beats[0] = '{out_byte: nal_byte, packet_first: 1'b0,
                                 packet_last: unit_end, run_last: 1'b1};
        end
        else
        begin
            if (packet_fill_reg == '0)
            begin
                load.count    = 2'd3;
                load.beats[0] = '{out_byte: fu_ind, packet_first: 1'b1,
                                     packet_last: 1'b0, run_last: 1'b0};
                load.beats[1] = '{out_byte: fu_hdr, packet_first: 1'b0,
                                     packet_last: 1'b0, run_last: 1'b0};
                load.beats[2] = '{out_byte: nal_byte, packet_first: 1'b0,
                                     packet_last: frag_last, run_last: 1'b1};
            end
            else
            begin
                load.count    = 2'd1;
                load.beats[0] = '{out_byte: nal_byte, packet_first: 1'b0,
                                     packet_last: frag_last, run_last: 1'b1};
            end
            packet_fill_next = frag_last ? '0 : (packet_fill_reg + 11'd1);
        end

        // end of unit wins over the fragment and fill updates above
        if (unit_end)
        begin
            byte_position_next = '0;
            fragmenting_next   = 1'b0;
            packet_fill_next   = '0;
        end
        else
        begin
            byte_position_next = byte_position_reg + NAL_LENGTH_BITS'(1);
        end
    end

    // unit state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg    <= '0;
            saved_nal_header_reg <= '0;
            packet_fill_reg      <= '0;
            fragmenting_reg      <= 1'b0;
        end
        else if (step)
        begin
            byte_position_reg    <= byte_position_next;
            saved_nal_header_reg <= saved_nal_header_next;
            packet_fill_reg      <= packet_fill_next;
            fragmenting_reg      <= fragmenting_next;
        end
    end

endmodule

### rtl/hnfp_beat_buffer.sv
module hnfp_beat_buffer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_en,
    input  hnfp_pkg::load_t   load,
    output logic              can_load,
    hnfp_rtp_if.source        rtp_out
);

    logic [1:0]      remaining_reg, remaining_next;
    hnfp_pkg::beat_t slot_reg [3];
    logic            take;

    assign take     = rtp_out.valid && rtp_out.ready;
    assign can_load = (remaining_reg == 2'd0) || ((remaining_reg == 2'd1) && rtp_out.ready);

    // head slot drives the output
    assign rtp_out.valid        = remaining_reg != 2'd0;
    assign rtp_out.out_byte     = slot_reg[0].out_byte;
    assign rtp_out.packet_first = slot_reg[0].packet_first;
    assign rtp_out.packet_last  = slot_reg[0].packet_last;
    assign rtp_out.run_last     = slot_reg[0].run_last;

    // beat count
    always_comb
    begin
        if (load_en)
            remaining_next = load.count;
        else if (take)
            remaining_next = remaining_reg - 2'd1;
        else
            remaining_next = remaining_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            remaining_reg <= 2'd0;
        else
            remaining_reg <= remaining_next;
    end

    // slots load together and shift toward the head
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            slot_reg[0] <= load.beats[0];
            slot_reg[1] <= load.beats[1];
            slot_reg[2] <= load.beats[2];
        end
        else if (take)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_en |-> can_load)
        else $error("beat buffer loaded while beats still pending");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (load_en && (load.count != 2'd0)) |=> rtp_out.valid)
        else $error("loaded beats not presented");

    a_tail_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (remaining_reg == 2'd1) |-> slot_reg[0].run_last)
        else $error("final pending beat lacks run_last");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg != 2'd3 || !$past(take) || $past(load_en))
        else $error("beat count rose without a load");
`endif

endmodule

### rtl/h264_nal_fragment_packetizer_core.sv
// h264 nal unit to rtp payload packetizer with fu-a fragmentation
// nal_in carries one unit byte per beat, header byte first, each beat tagged
// with the unit's total length. rtp_out carries rtp payload bytes with
// packet_first / packet_last framing and run_last on the final beat caused by
// each input byte. a unit no longer than max_packet_bytes (clamped to 4 to
// 2048) passes unchanged; a longer one is cut into fu-a fragments, each
// opened by an fu indicator and an fu header byte.
// an accepted input beat passes the input register, then the three-slot
// result buffer, before its first output beat.
// throughput: one byte per cycle when the receiver does not stall; the byte
// that opens a fragment yields three beats and holds the input while they
// drain, and the kept header of a fragmented unit yields none. the result
// buffer drains one beat per cycle while rtp_out.ready is high; when the
// receiver stalls it holds its beats and a full input register drops ready.
// reset clears the unit state and both stages and sets max_packet_bytes to
// 1024; the apb register at address 0 may be written only while idle.
module h264_nal_fragment_packetizer_core #(
    parameter int NAL_LENGTH_BITS = hnfp_pkg::NAL_LENGTH_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    hnfp_nal_if.sink                        nal_in,
    hnfp_rtp_if.source                      rtp_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hnfp_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [11:0]                max_packet_reg;
    logic                       in_valid_reg;
    logic [7:0]                 in_byte_reg;
    logic [NAL_LENGTH_BITS-1:0] in_len_reg;
    logic                       can_load;
    logic                       move;
    hnfp_pkg::load_t            load;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == hnfp_pkg::ADDR_MAX_PACKET) ? {20'd0, max_packet_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_packet_reg <= hnfp_pkg::MAX_PACKET_RESET;
        else if (psel && penable && pwrite && pready
                 && (paddr == hnfp_pkg::ADDR_MAX_PACKET))
            max_packet_reg <= pwdata[11:0];
    end

    // input register
    assign move         = in_valid_reg && can_load;
    assign nal_in.ready = !in_valid_reg || move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (nal_in.ready)
            in_valid_reg <= nal_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (nal_in.valid && nal_in.ready)
        begin
            in_byte_reg <= nal_in.nal_byte;
            in_len_reg  <= nal_in.nal_length;
        end
    end

    // packet framing
    hnfp_packer #(
        .NAL_LENGTH_BITS (NAL_LENGTH_BITS)
    ) u_packer (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (move),
        .nal_byte         (in_byte_reg),
        .nal_length       (in_len_reg),
        .max_packet_bytes (max_packet_reg),
        .load             (load)
    );

    // result beats toward the receiver
    hnfp_beat_buffer u_buffer (
        .clk      (clk),
        .rst_n    (rst_n),
        .load_en  (move),
        .load     (load),
        .can_load (can_load),
        .rtp_out  (rtp_out)
    );

`ifndef SYNTHESIS
    a_held_until_moved: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !move) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input register lost a pending byte");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> nal_in.ready)
        else $error("empty input register not ready");

    a_move_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        move |-> can_load)
        else $error("byte moved without buffer room");
`endif

endmodule

### tb/tb_h264_nal_fragment_packetizer_core.sv
// expected rtp payload beats, worked out from accepted nal bytes
class rtp_payload_board;
    localparam int LEN_W = hnfp_pkg::NAL_LENGTH_BITS_DEF;

    // packetizer state as seen by the predictor
    logic [LEN_W-1:0]        position;
    logic [7:0]              kept_header;
    logic [10:0]             frag_fill;
    bit                      fragmenting;
    logic [11:0]             max_packet;

    hnfp_pkg::beat_t         pending_beats[$];
    int unsigned             errors;
    int unsigned             bytes_noted;
    int unsigned             beats_matched;

    function new();
        position      = '0;
        kept_header   = '0;
        frag_fill     = '0;
        fragmenting   = 1'b0;
        max_packet    = hnfp_pkg::MAX_PACKET_RESET;
        errors        = 0;
        bytes_noted   = 0;
        beats_matched = 0;
    endfunction

    function void set_max_packet(input logic [11:0] value);
        max_packet = value;
    endfunction

    // register value clamped to the supported range
    function int unsigned effective_max();
        int unsigned v;
        v = max_packet;
        if (v < hnfp_pkg::MAX_PACKET_LO) v = hnfp_pkg::MAX_PACKET_LO;
        if (v > hnfp_pkg::MAX_PACKET_HI) v = hnfp_pkg::MAX_PACKET_HI;
        return v;
    endfunction

    function int unsigned unit_position();
        return position;
    endfunction

    function int unsigned pending();
        return pending_beats.size();
    endfunction

    // predict the beats one accepted nal byte causes
    function void absorb_nal_byte(input logic [7:0] b, input logic [LEN_W-1:0] len);
        int unsigned m, room, p, l, fill;
        bit unit_end, frag_end;
        logic [7:0] fu_ind, fu_hdr;
        logic [7:0] bytes[$];
        bit firsts[$];
        bit lasts[$];
        hnfp_pkg::beat_t bt;
        m = effective_max();
        room = m - hnfp_pkg::FU_BYTES;
        p = position;
        l = len;
        unit_end = (p + 1 >= l);
        bytes_noted++;
        if (p == 0) begin
            // header byte of an oversize unit is kept, nothing goes out
            if (l > m) begin
                kept_header = b;
                fragmenting = 1'b1;
                frag_fill   = '0;
                position    = LEN_W'(1);
                return;
            end
            fragmenting = 1'b0;
            frag_fill   = '0;
            bytes.push_back(b);
            firsts.push_back(1'b1);
            lasts.push_back(unit_end);
        end
        else if (!fragmenting) begin
            bytes.push_back(b);
            firsts.push_back(1'b0);
            lasts.push_back(unit_end);
        end
        else begin
            fill = frag_fill;
            // new fragment opens with fu indicator and fu header
            if (fill == 0) begin
                fu_ind = (kept_header & hnfp_pkg::NRI_MASK) | hnfp_pkg::FU_A_TYPE;
                fu_hdr = kept_header & hnfp_pkg::TYPE_MASK;
                if (p == 1) fu_hdr = fu_hdr | hnfp_pkg::FU_START_BIT;
                if (p + room >= l) fu_hdr = fu_hdr | hnfp_pkg::FU_END_BIT;
                bytes.push_back(fu_ind);
                firsts.push_back(1'b1);
                lasts.push_back(1'b0);
                bytes.push_back(fu_hdr);
                firsts.push_back(1'b0);
                lasts.push_back(1'b0);
            end
            frag_end = unit_end || (fill + 1 >= room);
            bytes.push_back(b);
            firsts.push_back(1'b0);
            lasts.push_back(frag_end);
            frag_fill = frag_end ? 11'd0 : 11'(fill + 1);
        end
        foreach (bytes[i]) begin
            bt.out_byte     = bytes[i];
            bt.packet_first = firsts[i];
            bt.packet_last  = lasts[i];
            bt.run_last     = (i == bytes.size() - 1);
            pending_beats.push_back(bt);
        end
        if (unit_end) begin
            position    = '0;
            fragmenting = 1'b0;
            frag_fill   = '0;
        end
        else begin
            position = LEN_W'(p + 1);
        end
    endfunction

    // compare one accepted rtp beat with the oldest prediction
    function void match_rtp_beat(input hnfp_pkg::beat_t got);
        hnfp_pkg::beat_t want;
        if (pending_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual byte %02h first %0b last %0b run %0b",
                     $time, got.out_byte, got.packet_first, got.packet_last, got.run_last);
            return;
        end
        want = pending_beats.pop_front();
        beats_matched++;
        if (got.out_byte !== want.out_byte) begin
            errors++;
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, want.out_byte, got.out_byte);
        end
        if (got.packet_first !== want.packet_first) begin
            errors++;
            $display("%0t: packet_first expected %0b actual %0b",
                     $time, want.packet_first, got.packet_first);
        end
        if (got.packet_last !== want.packet_last) begin
            errors++;
            $display("%0t: packet_last expected %0b actual %0b",
                     $time, want.packet_last, got.packet_last);
        end
        if (got.run_last !== want.run_last) begin
            errors++;
            $display("%0t: run_last expected %0b actual %0b",
                     $time, want.run_last, got.run_last);
        end
    endfunction
endclass

module tb_h264_nal_fragment_packetizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_W = hnfp_pkg::NAL_LENGTH_BITS_DEF;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [hnfp_pkg::PADDR_BITS-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    // no idling on either side while set
    bit                              calm;
    int unsigned                     settings_used;
    int unsigned                     readback_errors;

    rtp_payload_board                board;

    hnfp_nal_if #(.NAL_LENGTH_BITS(LEN_W)) nal ();
    hnfp_rtp_if                            rtp ();

    h264_nal_fragment_packetizer_core #(
        .NAL_LENGTH_BITS(LEN_W)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .nal_in  (nal),
        .rtp_out (rtp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // rtp sink with random back-pressure
    always @(posedge clk)
    begin : rtp_sink
        hnfp_pkg::beat_t got;
        if (!rst_n) begin
            rtp.ready <= 1'b0;
        end
        else begin
            if (rtp.valid && rtp.ready) begin
                got.out_byte     = rtp.out_byte;
                got.packet_first = rtp.packet_first;
                got.packet_last  = rtp.packet_last;
                got.run_last     = rtp.run_last;
                board.match_rtp_beat(got);
            end
            rtp.ready <= calm || ($urandom_range(99) >= 28);
        end
    end

    // one nal beat, with a random gap ahead of it
    task automatic send_byte(input logic [7:0] b, input logic [LEN_W-1:0] len);
        if (!calm && $urandom_range(99) < 28) begin
            nal.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 28);
        end
        nal.valid      <= 1'b1;
        nal.nal_byte   <= b;
        nal.nal_length <= len;
        do @(posedge clk); while (!nal.ready);
        board.absorb_nal_byte(b, len);
    endtask

    // end whatever unit is open with a length it already reached
    task automatic close_unit();
        int unsigned lim;
        lim = board.unit_position() + 1;
        send_byte(8'($urandom_range(255)), LEN_W'($urandom_range(0, lim)));
    endtask

    // a whole unit; when bent, the length changes part way through
    task automatic send_unit(input int unsigned len, input logic [7:0] hdr, input bit bent);
        int unsigned k;
        logic [LEN_W-1:0] l;
        if (board.unit_position() != 0) close_unit();
        k = (bent && len > 1) ? $urandom_range(1, len - 1) : len;
        l = LEN_W'(len);
        for (int unsigned i = 0; i < len; i++) begin
            if (i == k) l = LEN_W'($urandom());
            send_byte((i == 0) ? hdr : 8'($urandom_range(255)), l);
        end
    endtask

    // drop valid, wait for every predicted beat, then let the pipe empty
    task automatic settle();
        int unsigned n;
        n = 0;
        nal.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0 && n < 200000) begin
            @(posedge clk);
            n++;
        end
        repeat (6) @(posedge clk);
    endtask

    // apb write of max_packet_bytes, then read it back
    task automatic program_max(input logic [11:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hnfp_pkg::ADDR_MAX_PACKET;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.set_max_packet(value);
        settings_used++;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[11:0] !== value) begin
            readback_errors++;
            $display("%0t: max_packet_bytes readback expected %03h actual %03h",
                     $time, value, prdata[11:0]);
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // hard stop
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // main sequence
    initial
    begin
        logic [11:0] phase_max[$];
        int unsigned budget, m, r, len;
        board           = new();
        calm            = 1'b0;
        settings_used   = 0;
        readback_errors = 0;
        rst_n           = 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        nal.valid      <= 1'b0;
        nal.nal_byte   <= '0;
        nal.nal_length <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: one-byte unit, zero length, short pass-through at reset size
        send_unit(1, 8'hFF, 1'b0);
        send_byte(8'h00, '0);
        send_unit(3, 8'h65, 1'b0);
        settle();

        // directed: smallest size, exact fit, fragmented, length changing
        program_max(12'd4);
        send_unit(4, 8'h00, 1'b0);
        send_unit(5, 8'hFF, 1'b0);
        send_byte(8'h7C, 16'hFFFF);
        send_byte(8'hA5, 16'h8000);
        send_byte(8'h5A, 16'd2);
        settle();

        // directed: size shrinks in the middle of a fragment
        program_max(12'd10);
        send_byte(8'h41, 16'd30);
        for (int i = 0; i < 5; i++) send_byte(8'($urandom_range(255)), 16'd30);
        settle();
        program_max(12'd5);
        send_byte(8'($urandom_range(255)), 16'd30);
        send_byte(8'($urandom_range(255)), 16'd30);
        send_byte(8'($urandom_range(255)), 16'd1);
        settle();

        // random phases over several sizes, out-of-range ones included
        phase_max = {12'd4, 12'd6, 12'd3, 12'd11, 12'd2048, 12'd0, 12'hFFF, 12'd17,
                     12'($urandom_range(4, 40))};
        foreach (phase_max[ph]) begin
            program_max(phase_max[ph]);
            calm   = (ph == 3);
            m      = board.effective_max();
            budget = board.bytes_noted + (calm ? 40 : 14);
            while (board.bytes_noted < budget) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    send_byte(8'($urandom_range(255)), LEN_W'($urandom()));
                end
                else begin
                    len = (m >= 1024) ? $urandom_range(1, 12) : $urandom_range(1, 3 * m + 2);
                    send_unit(len, 8'($urandom_range(255)), r < 18);
                end
            end
            settle();
        end
        calm = 1'b0;

        $display("sent %0d nal bytes, matched %0d rtp beats over %0d packet size settings",
                 board.bytes_noted, board.beats_matched, settings_used);
        $display("leftover predicted beats: %0d", board.pending());
        if (board.errors == 0 && readback_errors == 0 && board.pending() == 0) begin
            $display("SUCCESS");
        end
        else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/hnfp_pkg.sv
rtl/hnfp_nal_if.sv
rtl/hnfp_rtp_if.sv
rtl/hnfp_packer.sv
rtl/hnfp_beat_buffer.sv
rtl/h264_nal_fragment_packetizer_core.sv
tb/tb_h264_nal_fragment_packetizer_core.sv
